### rtl/qp6r_pkg.sv
// shared types and constants for the quantized predictor-6 residual unit
// no dependencies; imported by quantized_pred6_residual_unit
package qp6r_pkg;

    // field widths
    localparam int SAMPLE_W    = 8;
    localparam int STEP_W      = 8;
    localparam int LINE_W_W    = 11;
    localparam int RES_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int DIV_CNT_W   = 3;

    // default row store depth
    localparam int MAX_LINE_DEF = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

    // register reset values
    localparam logic [STEP_W-1:0]   QUANT_STEP_RST = 8'd1;
    localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 11'd1024;

    // input beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
    } t_in;

    // output beat
    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic                    edge_sample;
    } t_out;

    // item sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC
    } t_state;

endpackage

### rtl/quantized_pred6_residual_unit.sv
// quantized predictor-6 residual unit: top level with row store and sequencer
// depends on qp6r_pkg
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one sample per
//   beat in raster order; frame_start restarts row and column for a new plane.
//   output channel (o_out_valid / i_out_stall / o_out_data) gives one residual
//   beat per input beat, in order.
//   config channel (i_cfg_valid / o_cfg_ready) writes quant_step (index 0) and
//   line_width (index 1); ready is high only while no item is in work.
// timing:
//   an item passes through the states idle, in which it is accepted and the
//   row store is read; divide, in which the bit-serial remainder unit
//   quantizes the sample; and calc, which forms the residual, writes the
//   row store and loads the output register. the result beat becomes valid as
//   the block returns to idle, and the next item can be accepted in that
//   same cycle. the 8-step remainder loop sets the rate; no new item is
//   accepted until the last one has committed.
// reset and stall:
//   synchronous reset returns to idle with quant_step 1, line_width 1024,
//   first row, column 0; the row store is not cleared (row 0 does not use what it reads).
//   a held output beat does not block the next accept; a finished item waits
//   in its last cycle until the output register is free.
module quantized_pred6_residual_unit #(
    parameter int MAX_LINE = qp6r_pkg::MAX_LINE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // input channel
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  qp6r_pkg::t_in                                 i_in_data,
    // output channel
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output qp6r_pkg::t_out                                o_out_data,
    // configuration channel
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [qp6r_pkg::CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [qp6r_pkg::CFG_DATA_W-1:0]               i_cfg_data
);
    import qp6r_pkg::*;

    localparam int AW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int CW = (LW > LINE_W_W) ? LW : LINE_W_W;

    // configuration registers
    logic [STEP_W-1:0]   r_quant_step;
    logic [LINE_W_W-1:0] r_line_width;

    // sequencer and position state
    t_state              r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [AW-1:0]       r_col;
    logic                r_first;
    logic [SAMPLE_W-1:0] r_left;
    logic [SAMPLE_W-1:0] r_upleft;

    // item in work
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_shift;
    logic [STEP_W-1:0]   r_rem;
    logic [SAMPLE_W-1:0] r_up;

    // row store
    logic [SAMPLE_W-1:0] r_row_mem [MAX_LINE];

    // output register
    logic                r_out_valid;
    t_out                r_out_data;

    logic                acc;
    logic                commit;
    logic                cfg_wr;
    logic [STEP_W-1:0]   step_eff;
    logic [CW-1:0]       width_ext;
    logic [CW-1:0]       width_clip;
    logic [LW-1:0]       eff_w;
    logic [AW-1:0]       col_base;
    logic                first_base;
    logic [AW-1:0]       col_acc;
    logic                first_acc;
    logic [STEP_W:0]     div_trial;
    logic                div_ge;
    logic [STEP_W-1:0]   n_rem;
    logic [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   half;
    logic signed [RES_W-1:0]    pred;
    logic signed [RES_W:0]      res_full;
    logic                edge_pix;
    logic [LW-1:0]       col_next;
    logic                row_end;

    // effective step and width
    assign step_eff   = (r_quant_step == '0) ? STEP_W'(1) : r_quant_step;
    assign width_ext  = CW'(r_line_width);
    assign width_clip = (width_ext == '0) ? CW'(1) :
                        (width_ext > CW'(MAX_LINE)) ? CW'(MAX_LINE) : width_ext;
    assign eff_w      = width_clip[LW-1:0];

    // handshakes
    assign acc         = i_in_valid && !o_in_stall;
    assign commit      = (r_state == ST_CALC) && (!r_out_valid || !i_out_stall);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // position of the accepted sample
    always_comb begin
        col_base   = i_in_data.frame_start ? '0 : r_col;
        first_base = i_in_data.frame_start ? 1'b1 : r_first;
        col_acc    = col_base;
        first_acc  = first_base;
        if (LW'(col_base) >= eff_w) begin
            col_acc   = '0;
            first_acc = 1'b0;
        end
    end

    // one remainder step per cycle
    assign div_trial = {r_rem, r_shift[SAMPLE_W-1]};
    assign div_ge    = div_trial >= {1'b0, step_eff};
    assign n_rem     = div_ge ? STEP_W'(div_trial - {1'b0, step_eff})
                              : div_trial[STEP_W-1:0];

    // residual datapath
    assign q        = r_sample - r_rem;
    assign diff     = $signed({1'b0, r_left}) - $signed({1'b0, r_upleft});
    assign half     = (diff + $signed({{SAMPLE_W{1'b0}}, diff[SAMPLE_W]})) >>> 1;
    assign pred     = $signed({2'b00, r_up}) + RES_W'(half);
    assign res_full = $signed({3'b000, q}) - RES_W'(pred);
    assign edge_pix = r_first || (r_col == '0);
    assign col_next = LW'(r_col) + LW'(1);
    assign row_end  = col_next >= eff_w;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == '1) n_state = ST_CALC;
            ST_CALC: if (commit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
            end
            ST_DIV, ST_CALC: begin
                o_in_stall  = 1'b1;
                o_cfg_ready = 1'b0;
            end
            default: begin
                o_in_stall  = 1'b1;
                o_cfg_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_col        <= '0;
            r_first      <= 1'b1;
            r_left       <= '0;
            r_upleft     <= '0;
            r_quant_step <= QUANT_STEP_RST;
            r_line_width <= LINE_WIDTH_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_QUANT_STEP: r_quant_step <= i_cfg_data[STEP_W-1:0];
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LINE_W_W-1:0];
                    default: ;
                endcase
            end
            // divider step count
            if (acc) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            // position bookkeeping
            if (acc) begin
                r_col   <= col_acc;
                r_first <= first_acc;
            end else if (commit) begin
                r_upleft <= r_up;
                r_left   <= q;
                if (row_end) begin
                    r_col   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_col <= col_next[AW-1:0];
                end
            end
            // output valid
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sample <= i_in_data.sample;
            r_shift  <= i_in_data.sample;
            r_rem    <= '0;
        end else if (r_state == ST_DIV) begin
            r_shift <= {r_shift[SAMPLE_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
        if (commit) begin
            // edge pixels carry the quantized sample itself
            r_out_data.residual    <= edge_pix ? $signed({{(RES_W-SAMPLE_W){1'b0}}, q})
                                               : res_full[RES_W-1:0];
            r_out_data.edge_sample <= edge_pix;
        end
    end

    // row store: read at accept, write back at commit
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_up <= r_row_mem[col_acc];
        end
        if (commit) begin
            r_row_mem[r_col] <= q;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_acc_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_DIV))
        else $error("accepted beat did not start the divider");

    a_rem_below_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_rem < step_eff))
        else $error("remainder not below step");

    a_edge_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.edge_sample) |-> !o_out_data.residual[RES_W-1])
        else $error("edge beat carries a negative value");

    a_cfg_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (r_state == ST_IDLE))
        else $error("config write while an item is in work");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("finished item did not reach the output register");

endmodule
